### design/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/pats_pkg.sv
// ---------------------------------------------------------------------------
// Priority aging task scheduler package
// Field widths, command codes, priority limits and shared types.
// ---------------------------------------------------------------------------
package pats_pkg;

   localparam int CMD_W  = 2;
   localparam int SLOT_W = 4;
   localparam int PRIO_W = 6;

   typedef logic [CMD_W-1:0]         cmd_type;
   typedef logic [SLOT_W-1:0]        slot_type;
   typedef logic signed [PRIO_W-1:0] prio_type;

   localparam cmd_type CMD_READY   = 2'd0;
   localparam cmd_type CMD_REMOVE  = 2'd1;
   localparam cmd_type CMD_SETPRIO = 2'd2;
   localparam cmd_type CMD_SCHED   = 2'd3;

   localparam prio_type PRIO_FLOOR = -6'sd20;
   localparam prio_type PRIO_CEIL  = 6'sd20;
   localparam prio_type AGE_LIMIT  = -6'sd19;
   localparam prio_type PRIO_MAX   = 6'sd31;

   typedef struct packed {
      logic     lt;
      prio_type dec;
   } cmp_res_type;

endpackage

### design/pats_cmp_unit.sv
// ---------------------------------------------------------------------------
// Shared compare and decrement unit
// Signed less-than compare of two priorities and decrement of the first.
// ---------------------------------------------------------------------------
module pats_cmp_unit (
   input  pats_pkg::prio_type    op_a,
   input  pats_pkg::prio_type    op_b,
   output pats_pkg::cmp_res_type res
);
   import pats_pkg::*;

   assign res.lt  = (op_a < op_b);
   assign res.dec = op_a - prio_type'(1);

endmodule

### design/priority_aging_task_scheduler.sv
// ---------------------------------------------------------------------------
// Priority aging task scheduler
// Make ready, set priority and ignored commands pass from acceptance through
// the execute and finish states to the response. Remove of a ready slot walks
// the ready list once and schedule of a nonempty list walks it twice (scan and
// age) through one shared compare unit. A finished response may wait while the next request is taken.
// Synchronous reset clears all priorities, ready marks and the ready count.
// ---------------------------------------------------------------------------
module priority_aging_task_scheduler #(
   parameter int SLOTS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  pats_pkg::cmd_type          req_cmd,
   input  pats_pkg::slot_type         req_slot,
   input  pats_pkg::prio_type         req_prio,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output pats_pkg::slot_type         rsp_chosen_slot,
   output logic                       rsp_found,
   output logic                       rsp_status
);
   import pats_pkg::*;

   `include "assert_macros.svh"

   localparam int IDX_W = $clog2(SLOTS);
   localparam int CNT_W = $clog2(SLOTS + 1);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_EXEC   = 3'd1;
   localparam logic [2:0] S_REMOVE = 3'd2;
   localparam logic [2:0] S_SCAN   = 3'd3;
   localparam logic [2:0] S_AGE    = 3'd4;
   localparam logic [2:0] S_FIN    = 3'd5;

   logic [2:0]       state_ff, state_in;
   cmd_type          cmd_ff, cmd_in;
   slot_type         slot_ff, slot_in;
   prio_type         prio_ff, prio_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] i_ff, i_in;
   logic [CNT_W-1:0] j_ff, j_in;
   logic [IDX_W-1:0] best_ff, best_in;
   prio_type         bp_ff, bp_in;
   logic             res_found_ff, res_found_in;
   logic             res_status_ff, res_status_in;
   logic             rsp_valid_ff, rsp_valid_in;
   slot_type         rsp_chosen_ff;
   logic             rsp_found_ff;
   logic             rsp_status_ff;
   logic             rsp_load;

   prio_type         stat_ff [SLOTS];
   prio_type         dyn_ff [SLOTS];
   logic [SLOTS-1:0] mark_ff;
   logic [IDX_W-1:0] order_ff [SLOTS];

   logic             dyn_we;
   logic [IDX_W-1:0] dyn_wa;
   prio_type         dyn_wd;
   logic             stat_we;
   logic             mark_we;
   logic             mark_wd;
   logic             ord_we;
   logic [IDX_W-1:0] ord_wa;
   logic [IDX_W-1:0] ord_wd;

   logic [IDX_W-1:0] s_idx;
   logic             slot_ok;
   logic [IDX_W-1:0] order_rd;
   prio_type         dyn_rd;
   prio_type         clamped;
   prio_type         cmp_b;
   cmp_res_type      cmp_res;

   assign s_idx    = IDX_W'(slot_ff);
   assign slot_ok  = (int'(slot_ff) < SLOTS);
   assign order_rd = order_ff[i_ff[IDX_W-1:0]];
   assign dyn_rd   = dyn_ff[order_rd];
   assign cmp_b    = (state_ff == S_AGE) ? AGE_LIMIT : bp_ff;

   always_comb begin
      if (prio_ff < PRIO_FLOOR) begin
         clamped = PRIO_FLOOR;
      end else if (prio_ff > PRIO_CEIL) begin
         clamped = PRIO_CEIL;
      end else begin
         clamped = prio_ff;
      end
   end

   pats_cmp_unit u_cmp (
      .op_a (dyn_rd),
      .op_b (cmp_b),
      .res  (cmp_res)
   );

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      slot_in       = slot_ff;
      prio_in       = prio_ff;
      count_in      = count_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      best_in       = best_ff;
      bp_in         = bp_ff;
      res_found_in  = res_found_ff;
      res_status_in = res_status_ff;
      rsp_load      = 1'b0;
      dyn_we        = 1'b0;
      dyn_wa        = s_idx;
      dyn_wd        = clamped;
      stat_we       = 1'b0;
      mark_we       = 1'b0;
      mark_wd       = 1'b0;
      ord_we        = 1'b0;
      ord_wa        = j_ff[IDX_W-1:0];
      ord_wd        = order_rd;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in   = req_cmd;
               slot_in  = req_slot;
               prio_in  = req_prio;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            res_found_in  = 1'b0;
            res_status_in = 1'b1;
            i_in          = '0;
            j_in          = '0;
            state_in      = S_FIN;
            if (cmd_ff == CMD_SCHED) begin
               if (count_ff != '0) begin
                  bp_in    = PRIO_MAX;
                  state_in = S_SCAN;
               end
            end else if (slot_ok) begin
               unique case (cmd_ff)
                  CMD_READY: begin
                     if (!mark_ff[s_idx] && (count_ff < CNT_W'(SLOTS))) begin
                        ord_we        = 1'b1;
                        ord_wa        = count_ff[IDX_W-1:0];
                        ord_wd        = s_idx;
                        count_in      = count_ff + CNT_W'(1);
                        mark_we       = 1'b1;
                        mark_wd       = 1'b1;
                        res_status_in = 1'b0;
                     end
                  end
                  CMD_REMOVE: begin
                     if (mark_ff[s_idx]) begin
                        state_in = S_REMOVE;
                     end
                  end
                  CMD_SETPRIO: begin
                     stat_we       = 1'b1;
                     dyn_we        = 1'b1;
                     res_status_in = 1'b0;
                  end
                  default: begin
                     state_in = S_FIN;
                  end
               endcase
            end
         end
         S_REMOVE: begin
            if (i_ff < count_ff) begin
               if (order_rd != s_idx) begin
                  ord_we = 1'b1;
                  j_in   = j_ff + CNT_W'(1);
               end
               i_in = i_ff + CNT_W'(1);
            end else begin
               count_in      = j_ff;
               mark_we       = 1'b1;
               mark_wd       = 1'b0;
               res_status_in = 1'b0;
               state_in      = S_FIN;
            end
         end
         S_SCAN: begin
            if (i_ff < count_ff) begin
               if (cmp_res.lt) begin
                  best_in = order_rd;
                  bp_in   = dyn_rd;
               end
               i_in = i_ff + CNT_W'(1);
            end else begin
               i_in     = '0;
               state_in = S_AGE;
            end
         end
         S_AGE: begin
            dyn_we = 1'b1;
            if (i_ff < count_ff) begin
               dyn_wa = order_rd;
               dyn_wd = cmp_res.lt ? dyn_rd : cmp_res.dec;
               i_in   = i_ff + CNT_W'(1);
            end else begin
               dyn_wa        = best_ff;
               dyn_wd        = stat_ff[best_ff];
               res_found_in  = 1'b1;
               res_status_in = 1'b0;
               state_in      = S_FIN;
            end
         end
         S_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      slot_ff       <= slot_in;
      prio_ff       <= prio_in;
      i_ff          <= i_in;
      j_ff          <= j_in;
      best_ff       <= best_in;
      bp_ff         <= bp_in;
      res_found_ff  <= res_found_in;
      res_status_ff <= res_status_in;
      if (rsp_load) begin
         rsp_chosen_ff <= res_found_ff ? SLOT_W'(best_ff) : '0;
         rsp_found_ff  <= res_found_ff;
         rsp_status_ff <= res_status_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < SLOTS; k++) begin
            stat_ff[k] <= '0;
            dyn_ff[k]  <= '0;
         end
         mark_ff <= '0;
      end else begin
         if (stat_we) begin
            stat_ff[s_idx] <= clamped;
         end
         if (dyn_we) begin
            dyn_ff[dyn_wa] <= dyn_wd;
         end
         if (mark_we) begin
            mark_ff[s_idx] <= mark_wd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ord_we) begin
         order_ff[ord_wa] <= ord_wd;
      end
   end

   assign req_stall       = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_chosen_slot = rsp_chosen_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_status      = rsp_status_ff;

   `ASSERT_IMPL(a_count_bound, 1'b1, count_ff <= CNT_W'(SLOTS), "Ready count above slot count.")
   `ASSERT_IMPL(a_mark_count, state_ff == S_IDLE, $countones(mark_ff) == int'(count_ff), "Ready marks disagree with the ready count.")
   `ASSERT_IMPL(a_found_status, rsp_valid && rsp_found, !rsp_status, "Found transaction reports ignored status.")
   `ASSERT_NEXT(a_fin_hold, state_ff == S_FIN && rsp_valid_ff && rsp_stall, state_ff == S_FIN, "Result left before the response slot was free.")

endmodule

### tb/sv/priority_aging_task_scheduler_tb.sv
// ---------------------------------------------------------------------------
// Priority aging task scheduler testbench
// Drives make ready, remove, set priority and schedule commands: a directed
// opening and then biased random traffic in bursts and gaps. The receiver
// stalls on a random pattern, with one long hold that backs up the request
// channel. Every response is checked against a cycle-free model of the slot
// table, ready list and aging rule.
// ---------------------------------------------------------------------------
module priority_aging_task_scheduler_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import pats_pkg::*;

   localparam int NUM_SLOTS      = 16;
   localparam int RANDOM_ITEMS   = 450;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int TAIL_CYCLES    = 50;
   localparam int LONG_HOLD      = 400;
   localparam int HOLD_AFTER     = 150;

   typedef struct packed {
      cmd_type  cmd;
      slot_type slot;
      prio_type prio;
   } task_req_type;

   typedef struct packed {
      slot_type chosen;
      logic     found;
      logic     status;
   } sched_rsp_type;

   logic     clock     = 1'b0;
   logic     reset     = 1'b1;
   logic     req_valid = 1'b0;
   logic     req_stall;
   cmd_type  req_cmd   = CMD_READY;
   slot_type req_slot  = '0;
   prio_type req_prio  = '0;
   logic     rsp_valid;
   logic     rsp_stall = 1'b0;
   slot_type rsp_chosen_slot;
   logic     rsp_found;
   logic     rsp_status;

   task_req_type  pending_q[$];
   sched_rsp_type expected_q[$];

   prio_type stat_prio[NUM_SLOTS];
   prio_type dyn_prio[NUM_SLOTS];
   logic     is_ready[NUM_SLOTS];
   slot_type ready_list[NUM_SLOTS];
   int       ready_len;

   int mismatches = 0;
   int rsp_seen   = 0;

   priority_aging_task_scheduler #(
      .SLOTS(NUM_SLOTS)
   ) i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_slot        (req_slot),
      .req_prio        (req_prio),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_chosen_slot (rsp_chosen_slot),
      .rsp_found       (rsp_found),
      .rsp_status      (rsp_status)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic sched_rsp_type apply_command(cmd_type cmd, slot_type slot,
                                                   prio_type prio);
      sched_rsp_type r;
      int            best;
      int            s;
      int            i;
      int            j;
      r        = '0;
      r.status = 1'b1;
      case (cmd)
         CMD_SCHED: begin
            if (ready_len > 0) begin
               best = ready_list[0];
               for (i = 1; i < ready_len; i++) begin
                  s = ready_list[i];
                  if (dyn_prio[s] < dyn_prio[best]) best = s;
               end
               for (i = 0; i < ready_len; i++) begin
                  s = ready_list[i];
                  if (dyn_prio[s] > PRIO_FLOOR) dyn_prio[s] = dyn_prio[s] - 6'sd1;
               end
               dyn_prio[best] = stat_prio[best];
               r.chosen = slot_type'(best);
               r.found  = 1'b1;
               r.status = 1'b0;
            end
         end
         CMD_READY: begin
            if (!is_ready[slot] && ready_len < NUM_SLOTS) begin
               ready_list[ready_len] = slot;
               ready_len++;
               is_ready[slot] = 1'b1;
               r.status = 1'b0;
            end
         end
         CMD_REMOVE: begin
            if (is_ready[slot]) begin
               j = 0;
               for (i = 0; i < ready_len; i++) begin
                  if (ready_list[i] != slot) begin
                     ready_list[j] = ready_list[i];
                     j++;
                  end
               end
               ready_len = j;
               is_ready[slot] = 1'b0;
               r.status = 1'b0;
            end
         end
         default: begin
            if (prio < PRIO_FLOOR) stat_prio[slot] = PRIO_FLOOR;
            else if (prio > PRIO_CEIL) stat_prio[slot] = PRIO_CEIL;
            else stat_prio[slot] = prio;
            dyn_prio[slot] = stat_prio[slot];
            r.status = 1'b0;
         end
      endcase
      return r;
   endfunction

   function automatic void add_req(cmd_type c, slot_type s, prio_type p);
      task_req_type t;
      t.cmd  = c;
      t.slot = s;
      t.prio = p;
      pending_q.push_back(t);
   endfunction

   // Sender: bursts of transactions separated by random gaps.
   int           burst_left = 0;
   int           gap_left   = 0;
   task_req_type next_req;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_q.push_back(apply_command(req_cmd, req_slot, req_prio));
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_q.size() > 0) begin
               next_req = pending_q.pop_front();
               req_valid <= 1'b1;
               req_cmd   <= next_req.cmd;
               req_slot  <= next_req.slot;
               req_prio  <= next_req.prio;
               if (burst_left > 0) burst_left--;
               if (burst_left == 0) begin
                  case ($urandom_range(4))
                     0: begin
                        burst_left = $urandom_range(40, 80);
                        gap_left   = 0;
                     end
                     1: begin
                        burst_left = $urandom_range(1, 10);
                        gap_left   = $urandom_range(10, 40);
                     end
                     default: begin
                        burst_left = $urandom_range(1, 30);
                        gap_left   = $urandom_range(0, 6);
                     end
                  endcase
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: random stall pattern in phases, plus one long hold.
   int   hold_left  = 0;
   logic hold_done  = 1'b0;
   int   phase_left = 0;
   int   stall_mode = 0;
   logic stall_next;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (!hold_done && rsp_seen >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            stall_next = 1'b1;
         end else begin
            if (phase_left == 0) begin
               stall_mode = $urandom_range(3);
               phase_left = $urandom_range(10, 80);
            end
            phase_left--;
            case (stall_mode)
               0: stall_next = 1'b0;
               1: stall_next = ($urandom_range(3) == 0);
               2: stall_next = ($urandom_range(1) == 0);
               default: stall_next = ($urandom_range(3) != 0);
            endcase
         end
         rsp_stall <= stall_next;
      end
   end

   // Monitor: compare each accepted response with the oldest prediction.
   sched_rsp_type want;

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_seen <= rsp_seen + 1;
         if (expected_q.size() == 0) begin
            if (mismatches < 10) begin
               $display("unexpected response: slot=%0d found=%0b status=%0b",
                        rsp_chosen_slot, rsp_found, rsp_status);
            end
            mismatches++;
         end else begin
            want = expected_q.pop_front();
            if (rsp_chosen_slot !== want.chosen || rsp_found !== want.found ||
                rsp_status !== want.status) begin
               if (mismatches < 10) begin
                  $display("mismatch: expected slot=%0d found=%0b status=%0b, got slot=%0d found=%0b status=%0b",
                           want.chosen, want.found, want.status,
                           rsp_chosen_slot, rsp_found, rsp_status);
               end
               mismatches++;
            end
         end
      end
   end

   int idle_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
         $display("Regression FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   int      n;
   int      w_ready;
   int      r;
   int      v;
   cmd_type c;

   initial begin
      for (n = 0; n < NUM_SLOTS; n++) begin
         stat_prio[n]  = '0;
         dyn_prio[n]   = '0;
         is_ready[n]   = 1'b0;
         ready_list[n] = '0;
      end
      ready_len = 0;

      add_req(CMD_SCHED,   4'd0,  prio_type'(0));
      add_req(CMD_REMOVE,  4'd3,  prio_type'(0));
      add_req(CMD_SETPRIO, 4'd0,  prio_type'(-32));
      add_req(CMD_SETPRIO, 4'd1,  prio_type'(31));
      add_req(CMD_SETPRIO, 4'd2,  prio_type'(-20));
      add_req(CMD_SETPRIO, 4'd15, prio_type'(20));
      add_req(CMD_SETPRIO, 4'd3,  prio_type'(-21));
      add_req(CMD_SETPRIO, 4'd4,  prio_type'(21));
      add_req(CMD_READY,   4'd15, prio_type'(0));
      add_req(CMD_READY,   4'd0,  prio_type'(0));
      add_req(CMD_READY,   4'd0,  prio_type'(0));
      add_req(CMD_READY,   4'd1,  prio_type'(0));
      add_req(CMD_READY,   4'd2,  prio_type'(0));
      add_req(CMD_READY,   4'd5,  prio_type'(0));
      add_req(CMD_SCHED,   4'd0,  prio_type'(0));
      add_req(CMD_SCHED,   4'd15, prio_type'(-1));
      add_req(CMD_SCHED,   4'd0,  prio_type'(0));
      add_req(CMD_SETPRIO, 4'd15, prio_type'(-20));
      add_req(CMD_SCHED,   4'd0,  prio_type'(0));
      add_req(CMD_REMOVE,  4'd0,  prio_type'(0));
      add_req(CMD_REMOVE,  4'd0,  prio_type'(0));
      add_req(CMD_REMOVE,  4'd15, prio_type'(0));
      add_req(CMD_SCHED,   4'd0,  prio_type'(0));
      add_req(CMD_SCHED,   4'd0,  prio_type'(0));
      add_req(CMD_SETPRIO, 4'd5,  prio_type'(0));

      w_ready = 30;
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 50 == 0) w_ready = $urandom_range(10, 45);
         r = $urandom_range(99);
         if (r < w_ready) c = CMD_READY;
         else if (r < 55) c = CMD_REMOVE;
         else if (r < 75) c = CMD_SETPRIO;
         else c = CMD_SCHED;
         if ($urandom_range(4) == 0) v = $urandom;
         else v = int'($urandom_range(40)) - 20;
         add_req(c, slot_type'($urandom_range(15)), prio_type'(v));
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      do @(posedge clock);
      while (pending_q.size() != 0 || req_valid || expected_q.size() != 0);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatches == 0 && expected_q.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
